@@ src/deadline_priority_queue_assert.svh @@
// Assertion macros shared by the deadline priority queue RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef DEADLINE_PRIORITY_QUEUE_ASSERT_SVH
`define DEADLINE_PRIORITY_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define DPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define DPQ_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define DPQ_ASSERT(label, prop, msg)
`define DPQ_NEVER(label, expr, msg)
`endif
`endif

@@ src/dpq_pkg.sv @@
// Shared types and constants of the deadline priority queue.
// No dependencies.
package dpq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_POP    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WNEW,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [7:0]  task_id;
		logic [15:0] deadline;
		logic [7:0]  task_kind;
		logic [15:0] create_tick;
		logic [16:0] key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ src/dpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/deadline_priority_queue.sv @@
// Deadline priority queue: sorted slot RAM walked by one compare/shift sequencer.
// Refused or trivial commands end via the FIN state; a pop or remove reads every held slot,
// and an insert reads from the tail down to its place (into an empty queue it writes the head).
// One command at a time; busy is low again in the cycle that shows done, so a
// new command may transfer then. The receiver cannot stall the done strobe.
// Reset clears the held count and control state; slot contents are not cleared.
`include "deadline_priority_queue_assert.svh"
module deadline_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [7:0]  task_id,
	input  logic [15:0] deadline,
	input  logic [7:0]  task_kind,
	input  logic [15:0] create_tick,
	output logic        done,
	output logic [1:0]  status,
	output logic [7:0]  out_task_id,
	output logic [15:0] out_deadline,
	output logic [7:0]  out_task_kind,
	output logic [15:0] out_create_tick,
	output logic [16:0] out_priority,
	output logic [4:0]  entry_count,
	output logic        head_valid,
	output logic [7:0]  head_task_id,
	output logic [16:0] head_priority
);

	localparam int IW = dpq_pkg::IDX_W;
	localparam int CW = dpq_pkg::CNT_W;

	dpq_pkg::state_t  state_q, state_d;
	dpq_pkg::cmd_t    cmd_q, cmd_d;
	dpq_pkg::status_t st_q, st_d;
	dpq_pkg::entry_t  new_q, new_d;
	dpq_pkg::entry_t  rem_q, rem_d;
	dpq_pkg::entry_t  rd_ent;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [7:0]       head_id_q, head_id_d;
	logic [16:0]      head_key_q, head_key_d;
	logic [IW-1:0]    rd_idx_q, rd_idx_d;
	logic             rd_more_q, rd_more_d;
	logic             ev_vld_s1, ev_vld_d;
	logic [IW-1:0]    ev_idx_s1, ev_idx_d;
	logic             found_q, found_d;
	logic             found0_q, found0_d;
	logic             done_q, done_d;
	logic [IW-1:0]    last_idx;
	logic             match;
	logic             is_full;

	logic                          ram_we;
	logic [IW-1:0]                 ram_waddr;
	logic [dpq_pkg::ENTRY_W-1:0]   ram_wdata;
	logic [dpq_pkg::ENTRY_W-1:0]   ram_rdata;

	dpq_ram #(
		.WIDTH (dpq_pkg::ENTRY_W),
		.DEPTH (dpq_pkg::DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	assign rd_ent   = ram_rdata;
	assign last_idx = IW'(cnt_q - CW'(1));
	assign is_full  = (cnt_q == CW'(dpq_pkg::DEPTH));
	assign match    = (cmd_q == dpq_pkg::CMD_POP) ? (ev_idx_s1 == '0)
	                                              : (rd_ent.task_id == new_q.task_id);

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dpq_pkg::S_IDLE;
			cnt_q      <= '0;
			rd_more_q  <= 1'b0;
			ev_vld_s1  <= 1'b0;
			found_q    <= 1'b0;
			found0_q   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			rd_more_q  <= rd_more_d;
			ev_vld_s1  <= ev_vld_d;
			found_q    <= found_d;
			found0_q   <= found0_d;
			done_q     <= done_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		st_q       <= st_d;
		new_q      <= new_d;
		rem_q      <= rem_d;
		head_id_q  <= head_id_d;
		head_key_q <= head_key_d;
		rd_idx_q   <= rd_idx_d;
		ev_idx_s1  <= ev_idx_d;
	end

	// sequencer: search and shift one slot per cycle
	always_comb begin
		state_d    = state_q;
		cmd_d      = cmd_q;
		st_d       = st_q;
		new_d      = new_q;
		rem_d      = rem_q;
		cnt_d      = cnt_q;
		head_id_d  = head_id_q;
		head_key_d = head_key_q;
		rd_idx_d   = rd_idx_q;
		rd_more_d  = rd_more_q;
		ev_vld_d   = 1'b0;
		ev_idx_d   = ev_idx_s1;
		found_d    = found_q;
		found0_d   = found0_q;
		done_d     = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = new_q;

		unique case (state_q)
			dpq_pkg::S_IDLE: begin
				if (start) begin
					cmd_d               = dpq_pkg::cmd_t'(command);
					new_d.task_id       = task_id;
					new_d.deadline      = deadline;
					new_d.task_kind     = task_kind;
					new_d.create_tick   = create_tick;
					new_d.key           = 17'(deadline) + 17'(create_tick);
					rem_d               = '0;
					found_d             = 1'b0;
					found0_d            = 1'b0;
					rd_more_d           = 1'b0;
					unique case (dpq_pkg::cmd_t'(command)) inside
						dpq_pkg::CMD_INSERT: begin
							if (is_full) begin
								st_d    = dpq_pkg::STAT_FULL;
								state_d = dpq_pkg::S_FIN;
							end else if (cnt_q == '0) begin
								st_d    = dpq_pkg::STAT_OK;
								state_d = dpq_pkg::S_WNEW;
							end else begin
								st_d      = dpq_pkg::STAT_OK;
								rd_idx_d  = last_idx;
								rd_more_d = 1'b1;
								state_d   = dpq_pkg::S_SCAN;
							end
						end
						dpq_pkg::CMD_POP, dpq_pkg::CMD_REMOVE: begin
							st_d = dpq_pkg::STAT_EMPTY;
							if (cnt_q == '0) begin
								state_d = dpq_pkg::S_FIN;
							end else begin
								rd_idx_d  = '0;
								rd_more_d = 1'b1;
								state_d   = dpq_pkg::S_SCAN;
							end
						end
						default: begin
							st_d    = dpq_pkg::STAT_EMPTY;
							state_d = dpq_pkg::S_FIN;
						end
					endcase
				end
			end

			dpq_pkg::S_SCAN: begin
				// issue the next slot read
				if (rd_more_q) begin
					ev_vld_d = 1'b1;
					ev_idx_d = rd_idx_q;
					if (cmd_q == dpq_pkg::CMD_INSERT) begin
						rd_idx_d  = rd_idx_q - IW'(1);
						rd_more_d = (rd_idx_q != '0);
					end else begin
						rd_idx_d  = rd_idx_q + IW'(1);
						rd_more_d = (rd_idx_q != last_idx);
					end
				end
				// evaluate the slot read last cycle
				if (ev_vld_s1) begin
					if (cmd_q == dpq_pkg::CMD_INSERT) begin
						ram_we    = 1'b1;
						ram_waddr = ev_idx_s1 + IW'(1);
						if (rd_ent.key >= new_q.key) begin
							// shift this slot up; new entry goes below it
							ram_wdata = rd_ent;
							if (ev_idx_s1 == '0) begin
								state_d = dpq_pkg::S_WNEW;
							end
						end else begin
							ram_wdata = new_q;
							cnt_d     = cnt_q + CW'(1);
							done_d    = 1'b1;
							state_d   = dpq_pkg::S_IDLE;
						end
					end else begin
						if (!found_q && match) begin
							rem_d    = rd_ent;
							found_d  = 1'b1;
							found0_d = (ev_idx_s1 == '0);
							st_d     = dpq_pkg::STAT_OK;
						end else if (found_q) begin
							// close the gap left by the removed slot
							ram_we    = 1'b1;
							ram_waddr = ev_idx_s1 - IW'(1);
							ram_wdata = rd_ent;
							if (found0_q && ev_idx_s1 == IW'(1)) begin
								head_id_d  = rd_ent.task_id;
								head_key_d = rd_ent.key;
							end
						end
						if (ev_idx_s1 == last_idx) begin
							if (found_q || match) begin
								cnt_d = cnt_q - CW'(1);
							end
							rd_more_d = 1'b0;
							done_d    = 1'b1;
							state_d   = dpq_pkg::S_IDLE;
						end
					end
				end
			end

			dpq_pkg::S_WNEW: begin
				// new entry becomes the head
				ram_we     = 1'b1;
				ram_waddr  = '0;
				ram_wdata  = new_q;
				head_id_d  = new_q.task_id;
				head_key_d = new_q.key;
				cnt_d      = cnt_q + CW'(1);
				rd_more_d  = 1'b0;
				done_d     = 1'b1;
				state_d    = dpq_pkg::S_IDLE;
			end

			dpq_pkg::S_FIN: begin
				done_d  = 1'b1;
				state_d = dpq_pkg::S_IDLE;
			end

			default: begin
				state_d = dpq_pkg::S_IDLE;
			end
		endcase
	end

	// result ports
	assign busy              = (state_q != dpq_pkg::S_IDLE);
	assign done              = done_q;
	assign status            = st_q;
	assign out_task_id       = rem_q.task_id;
	assign out_deadline      = rem_q.deadline;
	assign out_task_kind     = rem_q.task_kind;
	assign out_create_tick   = rem_q.create_tick;
	assign out_priority      = rem_q.key;
	assign entry_count       = 5'(cnt_q);
	assign head_valid        = (cnt_q != '0);
	assign head_task_id      = head_valid ? head_id_q : 8'd0;
	assign head_priority     = head_valid ? head_key_q : 17'd0;

	// checks
	`DPQ_NEVER(a_cnt_bound, cnt_q > CW'(dpq_pkg::DEPTH), "held count above depth")
	`DPQ_ASSERT(a_done_pulse, done_q |=> !done_q, "result strobe longer than one cycle")
	`DPQ_ASSERT(a_busy_after_start, (start && !busy) |=> busy, "no busy after transfer")
	`DPQ_ASSERT(a_full_st, (done_q && st_q == dpq_pkg::STAT_FULL) |-> is_full, "full, slots free")
	`DPQ_NEVER(a_idle_write, ram_we && state_q == dpq_pkg::S_IDLE, "slot write while idle")

endmodule
